### design/assert_macros.svh
// Assertion helpers shared by the design modules.
// Both macros assume the enclosing module has i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Immediate-style check that must hold on every clock edge outside reset.
`define KHA_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error(msg);

// Check that a condition on one edge implies a consequence on the next edge.
`define KHA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/kha_pkg.sv
package kha_pkg;

    // Table geometry.
    localparam int ENTRIES = 64;
    localparam int IDX_W   = $clog2(ENTRIES);
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // Field widths fixed by the transaction format.
    localparam int SLOT_W  = 6;
    localparam int USED_W  = 7;
    localparam int KEY_W   = 32;
    localparam int BYTES_W = 48;

    // Action codes.
    localparam logic [1:0] ACT_RECORD = 2'd0;
    localparam logic [1:0] ACT_FRAME  = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;

    // Request payload.
    typedef struct packed {
        logic [1:0]  action;
        logic [15:0] site_file;
        logic [15:0] site_line;
        logic [31:0] alloc_size;
        logic [31:0] snapshot_seq;
        logic [31:0] frame_peak;
        logic [5:0]  read_slot;
    } t_req;

    // Response payload.
    typedef struct packed {
        logic [SLOT_W-1:0]  slot;
        logic               created;
        logic               dropped;
        logic               valid_res;
        logic [15:0]        out_file;
        logic [15:0]        out_line;
        logic [31:0]        out_allocs;
        logic [BYTES_W-1:0] out_bytes;
        logic [31:0]        out_seq;
        logic [USED_W-1:0]  used_entries;
        logic [31:0]        peak_ever;
        logic [31:0]        frames_seen;
    } t_rsp;

    // One table entry as held in the counter memory.
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [31:0]        allocs;
        logic [BYTES_W-1:0] bytes;
        logic [31:0]        seq;
    } t_entry;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;   // capture the accepted request
        logic look;   // run the key match and pick the table address
        logic read;   // read the entry at the chosen address
        logic write;  // update the table and load the response register
    } t_cmd;

endpackage

### design/kha_if.sv
// Request channel: valid/ready handshake carrying one request transaction.
interface kha_req_if;
    logic          valid;
    logic          ready;
    kha_pkg::t_req data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// Response channel: valid/ready handshake carrying one response transaction.
interface kha_rsp_if;
    logic          valid;
    logic          ready;
    kha_pkg::t_rsp data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### design/kha_ctrl.sv
`include "assert_macros.svh"

module kha_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  logic          i_out_ready,
    output logic          o_out_valid,
    output kha_pkg::t_cmd o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_LOOK = 4'b0010,
        S_READ = 4'b0100,
        S_UPD  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    // The response register can take a new value when empty or being drained.
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    // Sequencing of one transaction: capture, match, read, update.
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_LOOK;
                end
            end
            S_LOOK: begin
                o_cmd.look = 1'b1;
                n_state    = S_READ;
            end
            S_READ: begin
                o_cmd.read = 1'b1;
                n_state    = S_UPD;
            end
            S_UPD: begin
                if (out_free) begin
                    o_cmd.write = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State and response-valid registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // A response only appears as the update step completes.
    `KHA_ASSERT_NEXT(a_rsp_from_update, !r_out_valid, !r_out_valid || $past(r_state == S_UPD), "response valid rose outside the update step")

    // The update step never overwrites a response that is still waiting.
    `KHA_ASSERT_ALWAYS(a_no_overwrite, !o_cmd.write || out_free, "update while the response register is held")

endmodule

### design/kha_dp.sv
`include "assert_macros.svh"

module kha_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  kha_pkg::t_cmd i_cmd,
    input  kha_pkg::t_req i_req,
    output kha_pkg::t_rsp o_rsp
);

    // Key cells, one per entry, compared in parallel.
    logic [kha_pkg::KEY_W-1:0]   r_cam [kha_pkg::ENTRIES];
    // Counter memory, one read and one write port.
    kha_pkg::t_entry             r_mem [kha_pkg::ENTRIES];
    kha_pkg::t_entry             r_mem_q;
    kha_pkg::t_entry             wr_entry;

    kha_pkg::t_req               r_item;
    kha_pkg::t_rsp               r_rsp, n_rsp;

    logic [kha_pkg::CNT_W-1:0]   r_count, n_count;
    logic [31:0]                 r_peak, n_peak;
    logic [31:0]                 r_frames, n_frames;

    logic [kha_pkg::IDX_W-1:0]   r_addr;
    logic                        r_found;
    logic                        r_full;
    logic                        r_rd_ok;

    logic [kha_pkg::KEY_W-1:0]   key;
    logic [kha_pkg::ENTRIES-1:0] match;
    logic [kha_pkg::IDX_W-1:0]   hit;
    logic                        found;

    logic [31:0]                 base_allocs, new_allocs;
    logic [kha_pkg::BYTES_W-1:0] base_bytes, new_bytes;
    logic [kha_pkg::BYTES_W:0]   byte_sum;
    logic                        is_rec, rec_ok, rec_new, mem_we;

    assign key = {r_item.site_file, r_item.site_line};

    // Request capture.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_item <= i_req;
        end
    end

    // Parallel key match over the entries in use; the lowest match wins.
    always_comb begin
        hit = '0;
        for (int j = 0; j < kha_pkg::ENTRIES; j++) begin
            match[j] = (r_cam[j] == key) && (kha_pkg::CNT_W'(j) < r_count);
        end
        for (int j = kha_pkg::ENTRIES - 1; j >= 0; j--) begin
            if (match[j]) begin
                hit = kha_pkg::IDX_W'(j);
            end
        end
        found = |match;
    end

    // Address selection: matched entry, next free entry, or the requested slot.
    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            r_found <= found;
            r_full  <= (r_count == kha_pkg::CNT_W'(kha_pkg::ENTRIES));
            r_rd_ok <= (kha_pkg::CNT_W'(r_item.read_slot) < r_count);
            if (r_item.action == kha_pkg::ACT_RECORD) begin
                r_addr <= found ? hit : r_count[kha_pkg::IDX_W-1:0];
            end else begin
                r_addr <= kha_pkg::IDX_W'(r_item.read_slot);
            end
        end
    end

    // Saturating counter update for a record.
    always_comb begin
        is_rec      = (r_item.action == kha_pkg::ACT_RECORD);
        rec_ok      = r_found || !r_full;
        rec_new     = is_rec && !r_found && !r_full;
        mem_we      = i_cmd.write && is_rec && rec_ok;
        base_allocs = r_found ? r_mem_q.allocs : '0;
        base_bytes  = r_found ? r_mem_q.bytes : '0;
        new_allocs  = (&base_allocs) ? base_allocs : base_allocs + 32'd1;
        byte_sum    = {1'b0, base_bytes} + (kha_pkg::BYTES_W + 1)'(r_item.alloc_size);
        new_bytes   = byte_sum[kha_pkg::BYTES_W] ? '1 : byte_sum[kha_pkg::BYTES_W-1:0];
        wr_entry.key    = key;
        wr_entry.allocs = new_allocs;
        wr_entry.bytes  = new_bytes;
        wr_entry.seq    = r_item.snapshot_seq;
    end

    // Counter memory: registered read, single write.
    always_ff @(posedge i_clk) begin
        if (i_cmd.read) begin
            r_mem_q <= r_mem[r_addr];
        end
        if (mem_we) begin
            r_mem[r_addr] <= wr_entry;
        end
    end

    // A new key is placed in its cell when the entry is created.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write && rec_new) begin
            r_cam[r_addr] <= key;
        end
    end

    // Global counters and the response contents.
    always_comb begin
        n_count  = r_count;
        n_peak   = r_peak;
        n_frames = r_frames;
        n_rsp    = '0;
        case (r_item.action)
            kha_pkg::ACT_RECORD: begin
                if (rec_ok) begin
                    if (!r_found) begin
                        n_count = r_count + kha_pkg::CNT_W'(1);
                    end
                    n_rsp.slot       = kha_pkg::SLOT_W'(r_addr);
                    n_rsp.created    = !r_found;
                    n_rsp.valid_res  = 1'b1;
                    n_rsp.out_file   = r_item.site_file;
                    n_rsp.out_line   = r_item.site_line;
                    n_rsp.out_allocs = new_allocs;
                    n_rsp.out_bytes  = new_bytes;
                    n_rsp.out_seq    = r_item.snapshot_seq;
                end else begin
                    n_rsp.dropped = 1'b1;
                end
            end
            kha_pkg::ACT_FRAME: begin
                if (r_item.frame_peak > r_peak) begin
                    n_peak = r_item.frame_peak;
                end
                if (!(&r_frames)) begin
                    n_frames = r_frames + 32'd1;
                end
            end
            kha_pkg::ACT_READ: begin
                n_rsp.slot = kha_pkg::SLOT_W'(r_item.read_slot);
                if (r_rd_ok) begin
                    n_rsp.valid_res  = 1'b1;
                    n_rsp.out_file   = r_mem_q.key[31:16];
                    n_rsp.out_line   = r_mem_q.key[15:0];
                    n_rsp.out_allocs = r_mem_q.allocs;
                    n_rsp.out_bytes  = r_mem_q.bytes;
                    n_rsp.out_seq    = r_mem_q.seq;
                end
            end
            default: begin
                n_rsp = '0;
            end
        endcase
        n_rsp.used_entries = kha_pkg::USED_W'(n_count);
        n_rsp.peak_ever    = n_peak;
        n_rsp.frames_seen  = n_frames;
    end

    // State that survives between transactions.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_peak   <= '0;
            r_frames <= '0;
        end else if (i_cmd.write) begin
            r_count  <= n_count;
            r_peak   <= n_peak;
            r_frames <= n_frames;
        end
    end

    // Response register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.write) begin
            r_rsp <= n_rsp;
        end
    end

    assign o_rsp = r_rsp;

    // The fill count never passes the table size.
    `KHA_ASSERT_ALWAYS(a_count_range, r_count <= kha_pkg::CNT_W'(kha_pkg::ENTRIES), "entry count beyond table size")

    // Creating an entry grows the table by exactly one.
    `KHA_ASSERT_NEXT(a_count_step, i_cmd.write && rec_new, r_count == $past(r_count) + kha_pkg::CNT_W'(1), "entry count did not advance on create")

    // A matched entry really holds the searched key.
    `KHA_ASSERT_ALWAYS(a_hit_key, !(i_cmd.write && is_rec && r_found) || (r_cam[r_addr] == key), "matched cell does not hold the key")

endmodule

### design/keyed_hotspot_aggregator.sv
// Keyed hotspot aggregator: a 64-entry table of allocation sites keyed by
// file id and line, with saturating per-site allocation and byte counters.
// Request channel i_req carries record, frame-end and read transactions;
// response channel o_rsp returns exactly one response per request.
// A response is loaded in steps after its request is accepted: the accepting
// edge captures the request, the look state registers the parallel key
// match over all entry cells, the read state performs the registered read
// of the counter memory, and the update state applies the saturating update
// and write-back. The controller goes back to idle only after the update, so
// one request is processed at a time; no new request is taken until that update.
// The response register decouples the two sides: a new request is taken
// while an earlier response still waits. If the receiver stalls, the update
// step waits until the held response is taken, and no request is lost.
// Reset (synchronous, active low) empties the table, clears the peak value
// and the frame count; entry contents need no clearing since only entries
// below the fill count are ever searched or returned.
module keyed_hotspot_aggregator (
    input  logic      i_clk,
    input  logic      i_rst_n,
    kha_req_if.sink   i_req,
    kha_rsp_if.source o_rsp
);

    kha_pkg::t_cmd cmd;
    kha_pkg::t_rsp rsp;
    logic          in_ready;
    logic          out_valid;

    kha_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_rsp.ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    kha_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (cmd),
        .i_req   (i_req.data),
        .o_rsp   (rsp)
    );

    assign i_req.ready = in_ready;
    assign o_rsp.valid = out_valid;
    assign o_rsp.data  = rsp;

endmodule
